### sv/lsbx_pkg.sv
// shared types and constants for the lsb steganography extractor
`default_nettype none

package lsbx_pkg;

	localparam int SALT_BYTES = 16;
	localparam int IV_BYTES   = 16;
	localparam int LEN_POS    = 4 + 1 + SALT_BYTES + IV_BYTES;
	localparam int HDR_LEN    = LEN_POS + 4;
	// smallest pixel count whose three bits per pixel hold the header
	localparam int MIN_PIXELS = (HDR_LEN * 8 + 2) / 3;

	localparam int LANES = 3;

	localparam logic [1:0] REG_PIXEL_COUNT    = 2'd0;
	localparam logic [1:0] REG_MAGIC_WORD     = 2'd1;
	localparam logic [1:0] REG_FORMAT_VERSION = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TOO_SMALL = 3'd1;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
	localparam logic [2:0] ST_BAD_VER   = 3'd3;
	localparam logic [2:0] ST_ZERO_LEN  = 3'd4;
	localparam logic [2:0] ST_NO_ROOM   = 3'd5;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_PAYLOAD
	} phase_t;

	typedef struct packed {
		logic lsb;
		logic done;
	} lane_t;

	typedef struct packed {
		logic [7:0] bits;
		logic [2:0] cnt;
	} pack_t;

	typedef struct packed {
		logic       byte_done;
		logic [7:0] byte_val;
		pack_t      nxt;
	} merge_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       in_header;
		logic       last;
		logic [2:0] status;
	} res_t;

endpackage

`default_nettype wire

### sv/lsbx_lane.sv
// one color channel lane: takes the lsb and flags whether it closes a byte
`default_nettype none

module lsbx_lane (
	input  wire logic [7:0]     channel,
	input  wire logic [2:0]     cnt,
	input  wire logic [1:0]     offset,
	output lsbx_pkg::lane_t     lane
);
	import lsbx_pkg::*;

	logic [3:0] fill;

	// bits held once this lane's bit is in
	assign fill      = 4'(cnt) + 4'(offset) + 4'd1;
	assign lane.lsb  = channel[0];
	assign lane.done = (fill == 4'd8);

endmodule

`default_nettype wire

### sv/lsbx_merge.sv
// merges the three lane bits into the bit buffer and picks out a finished byte
`default_nettype none

module lsbx_merge (
	input  wire lsbx_pkg::pack_t   cur,
	input  wire lsbx_pkg::lane_t   lanes [lsbx_pkg::LANES],
	output lsbx_pkg::merge_t       mrg
);
	import lsbx_pkg::*;

	logic [10:0] full;

	assign full = {cur.bits, lanes[0].lsb, lanes[1].lsb, lanes[2].lsb};

	always_comb begin
		mrg.byte_done = 1'b0;
		mrg.byte_val  = full[10:3];
		mrg.nxt.bits  = full[7:0];
		mrg.nxt.cnt   = cur.cnt + 3'd3;
		if (lanes[0].done) begin
			mrg.byte_done = 1'b1;
			mrg.byte_val  = full[9:2];
			mrg.nxt.bits  = {6'd0, full[1:0]};
			mrg.nxt.cnt   = 3'd2;
		end else if (lanes[1].done) begin
			mrg.byte_done = 1'b1;
			mrg.byte_val  = full[8:1];
			mrg.nxt.bits  = {7'd0, full[0]};
			mrg.nxt.cnt   = 3'd1;
		end else if (lanes[2].done) begin
			mrg.byte_done = 1'b1;
			mrg.byte_val  = full[7:0];
			mrg.nxt.bits  = 8'd0;
			mrg.nxt.cnt   = 3'd0;
		end
	end

endmodule

`default_nettype wire

### sv/lsbx_ctrl.sv
// frame control: configuration, header parsing and checks, payload count
`default_nettype none

module lsbx_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_addr,
	input  wire logic [31:0]      cfg_wdata,
	input  wire logic             pix_fire,
	input  wire logic             start,
	input  wire lsbx_pkg::merge_t mrg,
	output lsbx_pkg::pack_t       cur,
	output logic                  res_valid,
	output lsbx_pkg::res_t        res
);
	import lsbx_pkg::*;

	logic [28:0] pixel_count_q;
	logic [31:0] magic_word_q;
	logic [7:0]  format_version_q;

	phase_t      phase_q, phase_d, phase_b;
	pack_t       pack_q;
	logic [32:0] pos_q, pos_b, pos_inc;
	logic [31:0] len_q, len_b, len_d;
	logic [32:0] total_q, total_d;
	logic        magic_ok_q, magic_b, magic_d;
	logic [7:0]  ver_q, ver_b, ver_d;

	logic        too_small, run, byte_ev;
	logic [7:0]  want;
	logic        hdr_last, pay_last;
	logic [2:0]  hdr_status;
	logic [30:0] cap_bits;
	logic [35:0] need_bits;

	assign too_small = pixel_count_q < 29'(MIN_PIXELS);
	assign run       = start ? !too_small : (phase_q != PH_IDLE);
	assign byte_ev   = pix_fire && run && mrg.byte_done;

	assign phase_b = start ? PH_HEADER : phase_q;
	assign pos_b   = start ? 33'd0 : pos_q;
	assign len_b   = start ? 32'd0 : len_q;
	assign magic_b = start ? 1'b1 : magic_ok_q;
	assign ver_b   = start ? 8'd0 : ver_q;
	assign cur     = start ? '0 : pack_q;
	assign pos_inc = pos_b + 33'd1;

	always_comb begin
		case (pos_b[1:0])
			2'd0:    want = magic_word_q[31:24];
			2'd1:    want = magic_word_q[23:16];
			2'd2:    want = magic_word_q[15:8];
			default: want = magic_word_q[7:0];
		endcase
	end

	always_comb begin
		magic_d = magic_b;
		ver_d   = ver_b;
		len_d   = len_b;
		if (pos_b < 33'd4) begin
			magic_d = magic_b && (want == mrg.byte_val);
		end else if (pos_b == 33'd4) begin
			ver_d = mrg.byte_val;
		end else if (pos_b >= 33'(LEN_POS)) begin
			len_d = {len_b[23:0], mrg.byte_val};
		end
	end

	// capacity in bits against header plus payload in bits
	assign total_d   = 33'(HDR_LEN) + 33'(len_d);
	assign cap_bits  = {1'b0, pixel_count_q, 1'b0} + 31'(pixel_count_q);
	assign need_bits = {total_d, 3'b000};
	assign hdr_last  = (phase_b == PH_HEADER) && (pos_b == 33'(HDR_LEN - 1));
	assign pay_last  = (phase_b == PH_PAYLOAD) && (pos_inc == total_q);

	always_comb begin
		if (!magic_d) begin
			hdr_status = ST_BAD_MAGIC;
		end else if (ver_d != format_version_q) begin
			hdr_status = ST_BAD_VER;
		end else if (len_d == 32'd0) begin
			hdr_status = ST_ZERO_LEN;
		end else if (need_bits > 36'(cap_bits)) begin
			hdr_status = ST_NO_ROOM;
		end else begin
			hdr_status = ST_OK;
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		if (pix_fire) begin
			if (start && too_small) begin
				phase_d = PH_IDLE;
			end else if (byte_ev) begin
				case (phase_b)
					PH_HEADER: begin
						if (hdr_last) begin
							phase_d = (hdr_status != ST_OK) ? PH_IDLE : PH_PAYLOAD;
						end else begin
							phase_d = PH_HEADER;
						end
					end
					PH_PAYLOAD: phase_d = pay_last ? PH_IDLE : PH_PAYLOAD;
					default:    phase_d = PH_IDLE;
				endcase
			end else begin
				phase_d = phase_b;
			end
		end
	end

	// result request
	always_comb begin
		res_valid     = 1'b0;
		res.data_byte = mrg.byte_val;
		res.in_header = 1'b0;
		res.last      = 1'b0;
		res.status    = ST_OK;
		if (pix_fire && start && too_small) begin
			res_valid     = 1'b1;
			res.data_byte = 8'd0;
			res.last      = 1'b1;
			res.status    = ST_TOO_SMALL;
		end else if (byte_ev) begin
			res_valid = 1'b1;
			case (phase_b)
				PH_HEADER: begin
					res.in_header = 1'b1;
					if (hdr_last && hdr_status != ST_OK) begin
						res.last   = 1'b1;
						res.status = hdr_status;
					end
				end
				PH_PAYLOAD: res.last = pay_last;
				default:    res.last = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q    <= '0;
			magic_word_q     <= '0;
			format_version_q <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PIXEL_COUNT:    pixel_count_q    <= cfg_wdata[28:0];
				REG_MAGIC_WORD:     magic_word_q     <= cfg_wdata;
				REG_FORMAT_VERSION: format_version_q <= cfg_wdata[7:0];
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pack_q     <= '0;
			pos_q      <= '0;
			len_q      <= '0;
			total_q    <= '0;
			magic_ok_q <= 1'b1;
			ver_q      <= '0;
		end else if (pix_fire) begin
			phase_q <= phase_d;
			if (run) begin
				pack_q <= mrg.nxt;
			end else if (start) begin
				pack_q <= '0;
			end
			if (run && mrg.byte_done) begin
				pos_q <= pos_inc;
			end else if (start) begin
				pos_q <= '0;
			end
			if (run && mrg.byte_done && (phase_b == PH_HEADER)) begin
				magic_ok_q <= magic_d;
				ver_q      <= ver_d;
				len_q      <= len_d;
				total_q    <= total_d;
			end else if (start) begin
				len_q      <= '0;
				magic_ok_q <= 1'b1;
				ver_q      <= '0;
			end
		end
	end

endmodule

`default_nettype wire

### sv/lsb_stego_extractor.sv
// Pixel stream in, extracted message bytes out. One pixel is taken per clock while the
// output side keeps up; its three channel lsbs go through three lanes in parallel and at
// most one byte (header bytes included) leaves per pixel, registered at the output. The
// lane merge and the header check sit in that single stage, so the rate is one pixel per
// cycle unless stalled; a one-entry skid register behind the output register lets one
// more pixel in while a result is stalled. Start-of-image (tuser) restarts extraction;
// status is nonzero only on the final result of a failed frame, which also has tlast.
`default_nettype none

module lsb_stego_extractor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
	input  wire logic        s_tuser,   // start_of_image
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // data_byte [7:0]
	output logic [3:0]       m_tuser,   // in_header [0], status [3:1]
	output logic             m_tlast
);
	import lsbx_pkg::*;

	logic    pix_fire;
	lane_t   lanes [LANES];
	pack_t   cur;
	merge_t  mrg;
	logic    res_valid;
	res_t    res;

	res_t    out_q, skid_q;
	logic    out_valid_q, skid_valid_q;

	assign s_tready = !skid_valid_q;
	assign pix_fire = s_tvalid && s_tready;

	lsbx_lane u_lane_r (
		.channel (s_tdata[7:0]),
		.cnt     (cur.cnt),
		.offset  (2'd0),
		.lane    (lanes[0])
	);

	lsbx_lane u_lane_g (
		.channel (s_tdata[15:8]),
		.cnt     (cur.cnt),
		.offset  (2'd1),
		.lane    (lanes[1])
	);

	lsbx_lane u_lane_b (
		.channel (s_tdata[23:16]),
		.cnt     (cur.cnt),
		.offset  (2'd2),
		.lane    (lanes[2])
	);

	lsbx_merge u_merge (
		.cur   (cur),
		.lanes (lanes),
		.mrg   (mrg)
	);

	lsbx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.pix_fire  (pix_fire),
		.start     (s_tuser),
		.mrg       (mrg),
		.cur       (cur),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.data_byte;
	assign m_tuser  = {out_q.status, out_q.in_header};
	assign m_tlast  = out_q.last;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output request");

	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_tready && res_valid))
		else $error("skid entry filled without a stalled output");

	a_error_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[3:1] != ST_OK) |-> m_tlast)
		else $error("error status without last");

	a_too_small_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[3:1] == ST_TOO_SMALL) |-> !m_tuser[0] && (m_tdata == 8'd0))
		else $error("image too small result carries data");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking stream testbench for the lsb steganography extractor
`timescale 1ns / 1ps

module testbench;

	import lsbx_pkg::*;

	typedef struct packed {
		logic        sof;
		logic [23:0] rgb;
	} pixel_t;

	typedef enum int {
		FR_OK,
		FR_BAD_MAGIC,
		FR_BAD_VER,
		FR_ZERO_LEN,
		FR_NO_ROOM,
		FR_CUT,
		FR_NOISE
	} frame_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = REG_PIXEL_COUNT;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;

	lsb_stego_extractor uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // red [7:0], green [15:8], blue [23:16]
		.s_tuser   (s_tuser),   // start_of_image
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // data_byte [7:0]
		.m_tuser   (m_tuser),   // in_header [0], status [3:1]
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register copies and extraction state of the predictor
	logic [28:0] cfg_pixels = '0;
	logic [31:0] cfg_magic = '0;
	logic [7:0]  cfg_version = 8'd1;
	logic [7:0]  acc = '0;
	int          nbits = 0;
	logic [32:0] byte_pos = '0;
	logic [31:0] decl_len = '0;
	bit          magic_ok = 1'b1;
	logic [7:0]  ver_seen = '0;
	phase_t      ph = PH_IDLE;

	pixel_t pending_pixels[$];
	res_t   expected_bytes[$];
	int     pixels_queued = 0;
	int     pixels_taken = 0;
	int     bytes_checked = 0;
	int     errors = 0;
	int     gap_odds = 0;
	int     frames_made[7];
	int     undersized_frames = 0;
	int     phases_run = 0;
	logic   tx_fired = 1'b0;

	// one pixel in, at most one extracted byte (or status) out
	function automatic bit predict_byte(input logic [23:0] px, input logic sof, output res_t r);
		logic [2:0] lsbs;
		logic [7:0] b;
		logic [2:0] st;
		int c;
		int p;
		bit got;
		lsbs = {px[0], px[8], px[16]};
		got = 1'b0;
		r = '0;
		if (sof) begin
			acc = '0;
			nbits = 0;
			byte_pos = '0;
			decl_len = '0;
			magic_ok = 1'b1;
			ver_seen = '0;
			if (longint'(cfg_pixels) * 3 < longint'(HDR_LEN) * 8) begin
				ph = PH_IDLE;
				r.last = 1'b1;
				r.status = ST_TOO_SMALL;
				return 1'b1;
			end
			ph = PH_HEADER;
		end
		for (c = 0; c < LANES; c++) begin
			if (ph != PH_IDLE) begin
				acc = {acc[6:0], lsbs[2 - c]};
				nbits++;
				if (nbits == 8) begin
					b = acc;
					acc = '0;
					nbits = 0;
					got = 1'b1;
					r.data_byte = b;
					r.in_header = (ph == PH_HEADER);
					r.last = 1'b0;
					r.status = ST_OK;
					if (ph == PH_HEADER) begin
						p = int'(byte_pos);
						if (p < 4) begin
							if (8'(cfg_magic >> (24 - 8 * p)) != b)
								magic_ok = 1'b0;
						end else if (p == 4) begin
							ver_seen = b;
						end else if (p >= LEN_POS) begin
							decl_len = {decl_len[23:0], b};
						end
						byte_pos = byte_pos + 33'd1;
						if (p + 1 == HDR_LEN) begin
							st = ST_OK;
							if (!magic_ok)
								st = ST_BAD_MAGIC;
							else if (ver_seen != cfg_version)
								st = ST_BAD_VER;
							else if (decl_len == 0)
								st = ST_ZERO_LEN;
							else if ((longint'(HDR_LEN) + longint'(decl_len)) * 8 >
									longint'(cfg_pixels) * 3)
								st = ST_NO_ROOM;
							if (st != ST_OK) begin
								r.last = 1'b1;
								r.status = st;
								ph = PH_IDLE;
							end else begin
								ph = PH_PAYLOAD;
							end
						end
					end else begin
						byte_pos = byte_pos + 33'd1;
						if (longint'(byte_pos) >= longint'(HDR_LEN) + longint'(decl_len)) begin
							r.last = 1'b1;
							ph = PH_IDLE;
						end
					end
				end
			end
		end
		return got;
	endfunction

	// pixel source: holds each request until taken, random gaps between requests
	always @(negedge clk) begin
		int gap_left;
		pixel_t px;
		if (!s_tvalid || tx_fired) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (gap_odds > 0 && $urandom_range(0, gap_odds - 1) == 0) begin
				gap_left = $urandom_range(0, 3);
				s_tvalid <= 1'b0;
			end else if (pending_pixels.size() > 0) begin
				px = pending_pixels.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= px.rgb;
				s_tuser <= px.sof;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// byte sink: random stall bursts
	always @(negedge clk) begin
		int stall_left;
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (gap_odds > 0 && $urandom_range(0, gap_odds - 1) == 0) begin
			stall_left = $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		res_t want;
		res_t nxt;
		if (arst_n) begin
			tx_fired <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				pixels_taken++;
				if (predict_byte(s_tdata, s_tuser, nxt))
					expected_bytes.push_back(nxt);
			end
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected result: data_byte %h tuser %h tlast %b",
						m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					want = expected_bytes.pop_front();
					bytes_checked++;
					if (m_tdata !== want.data_byte) begin
						$error("data_byte expected %h actual %h", want.data_byte, m_tdata);
						errors++;
					end
					if (m_tuser[0] !== want.in_header) begin
						$error("in_header expected %b actual %b", want.in_header, m_tuser[0]);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$error("last expected %b actual %b", want.last, m_tlast);
						errors++;
					end
					if (m_tuser[3:1] !== want.status) begin
						$error("status expected %0d actual %0d", want.status, m_tuser[3:1]);
						errors++;
					end
				end
			end
		end
	end

	task automatic push_pixel(input logic [23:0] rgb, input logic sof);
		pixel_t px;
		px.rgb = rgb;
		px.sof = sof;
		pending_pixels.push_back(px);
		pixels_queued++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_PIXEL_COUNT:    cfg_pixels = val[28:0];
			REG_MAGIC_WORD:     cfg_magic = val;
			REG_FORMAT_VERSION: cfg_version = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for every pixel to be taken and every byte to come back, then let the pipe empty
	task automatic settle();
		while (pixels_taken != pixels_queued || expected_bytes.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic add_frame(input frame_kind_t kind);
		logic [7:0] msg[$];
		longint room;
		logic [31:0] len;
		logic [2:0] trip;
		frame_kind_t k;
		int npix;
		int n;
		int i;
		int p;
		int c;
		int bi;
		k = kind;
		if (k == FR_NOISE) begin
			n = $urandom_range(3, 12);
			repeat (n) push_pixel(24'($urandom()), $urandom_range(0, 7) == 0);
			frames_made[k]++;
			return;
		end
		if (cfg_pixels < MIN_PIXELS) begin
			push_pixel(24'($urandom()), 1'b1);
			n = $urandom_range(0, 2);
			repeat (n) push_pixel(24'($urandom()), 1'b0);
			undersized_frames++;
			return;
		end
		room = longint'(cfg_pixels) * 3 / 8 - HDR_LEN;
		if ((k == FR_OK || k == FR_CUT) && room < 1)
			k = FR_NO_ROOM;
		case (k)
			FR_OK, FR_CUT: begin
				if (room <= 40 && $urandom_range(0, 2) == 0)
					len = 32'(room);
				else
					len = $urandom_range(1, (room < 24) ? int'(room) : 24);
			end
			FR_BAD_MAGIC: len = $urandom_range(0, 1) ? 32'd0 : 32'd5;
			FR_BAD_VER:   len = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
			FR_ZERO_LEN:  len = 32'd0;
			default: begin
				// just past the capacity, or the largest length there is
				if ($urandom_range(0, 1))
					len = 32'(room + 1 + $urandom_range(0, 3));
				else
					len = 32'hFFFF_FFFF;
			end
		endcase
		for (i = 0; i < 4; i++)
			msg.push_back(8'(cfg_magic >> (24 - 8 * i)));
		if (k == FR_BAD_MAGIC) begin
			bi = $urandom_range(0, 3);
			msg[bi] = msg[bi] ^ 8'($urandom_range(1, 255));
		end
		if (k == FR_BAD_VER || (k == FR_BAD_MAGIC && $urandom_range(0, 1)))
			msg.push_back(cfg_version ^ 8'($urandom_range(1, 255)));
		else
			msg.push_back(cfg_version);
		repeat (SALT_BYTES + IV_BYTES) msg.push_back(8'($urandom()));
		for (i = 0; i < 4; i++)
			msg.push_back(8'(len >> (24 - 8 * i)));
		if (k == FR_OK || k == FR_CUT)
			repeat (len) msg.push_back(8'($urandom()));
		npix = (msg.size() * 8 + 2) / 3;
		if (k == FR_CUT)
			npix = $urandom_range(1, npix - 1);
		for (p = 0; p < npix; p++) begin
			for (c = 0; c < LANES; c++) begin
				bi = p * LANES + c;
				if (bi < msg.size() * 8)
					trip[2 - c] = msg[bi / 8][7 - bi % 8];
				else
					trip[2 - c] = 1'($urandom_range(0, 1));
			end
			push_pixel((24'($urandom()) & 24'hFEFEFE) |
				{7'd0, trip[0], 7'd0, trip[1], 7'd0, trip[2]}, p == 0);
		end
		// trailing pixels the block should ignore (or that extend a cut frame)
		n = $urandom_range(0, 2);
		repeat (n) push_pixel(24'($urandom()), 1'b0);
		frames_made[k]++;
	endtask

	initial begin
		int nfr;
		int sel;
		logic [31:0] pc;
		logic [31:0] mw;
		logic [7:0] fv;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		gap_odds = 4;

		// reset settings: pixel count 0, so every start is too small; idle pixels ignored
		push_pixel(24'hFFFFFF, 1'b1);
		push_pixel(24'h000000, 1'b0);
		push_pixel(24'hFFFFFF, 1'b0);
		push_pixel(24'h000000, 1'b1);
		settle();
		// one pixel short of a header
		write_reg(REG_PIXEL_COUNT, 32'(MIN_PIXELS - 1));
		write_reg(REG_MAGIC_WORD, 32'hFFFF_FFFF);
		write_reg(REG_FORMAT_VERSION, 32'hFF);
		push_pixel(24'h010101, 1'b1);
		push_pixel(24'hFEFEFE, 1'b0);
		settle();
		// exactly a header's worth: frame starts, then a start mid-header restarts it
		write_reg(REG_PIXEL_COUNT, 32'(MIN_PIXELS));
		push_pixel(24'hFEFEFE, 1'b1);
		repeat (4) push_pixel(24'($urandom()), 1'b0);
		push_pixel(24'hFFFFFF, 1'b1);
		push_pixel(24'hFFFFFF, 1'b1);
		repeat (3) push_pixel(24'($urandom()), 1'b0);
		settle();

		while (pixels_queued < 1700) begin
			sel = $urandom_range(0, 9);
			if (phases_run == 0) begin
				pc = 32'd268435456;
				mw = 32'hFFFF_FFFF;
				fv = 8'hFF;
			end else if (phases_run == 1) begin
				pc = 32'(MIN_PIXELS);
				mw = 32'h0;
				fv = 8'h00;
			end else begin
				if (sel == 0)
					pc = 32'($urandom_range(0, MIN_PIXELS - 1));
				else if (sel == 1)
					pc = 32'd268435456;
				else if (sel == 2)
					pc = 32'($urandom_range(MIN_PIXELS, 1 << 20));
				else
					pc = 32'($urandom_range(MIN_PIXELS, MIN_PIXELS + 140));
				sel = $urandom_range(0, 5);
				mw = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom();
				sel = $urandom_range(0, 5);
				fv = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : (sel == 2) ? 8'h01 :
					8'($urandom());
			end
			write_reg(REG_PIXEL_COUNT, pc);
			write_reg(REG_MAGIC_WORD, mw);
			write_reg(REG_FORMAT_VERSION, {24'd0, fv});
			if (pixels_queued > 1400) begin
				gap_odds = 0;
			end else begin
				sel = $urandom_range(0, 2);
				gap_odds = (sel == 0) ? 0 : (sel == 1) ? 3 : 7;
			end
			nfr = $urandom_range(3, 6);
			repeat (nfr) begin
				sel = $urandom_range(0, 99);
				if (sel < 55)
					add_frame(FR_OK);
				else if (sel < 63)
					add_frame(FR_BAD_MAGIC);
				else if (sel < 71)
					add_frame(FR_BAD_VER);
				else if (sel < 79)
					add_frame(FR_ZERO_LEN);
				else if (sel < 87)
					add_frame(FR_NO_ROOM);
				else if (sel < 95)
					add_frame(FR_CUT);
				else
					add_frame(FR_NOISE);
			end
			settle();
			phases_run++;
		end

		$display("covered %0d pixels over %0d register settings, %0d output bytes checked",
			pixels_taken, phases_run + 3, bytes_checked);
		$display("frames: ok %0d, bad magic %0d, bad version %0d, zero length %0d, no room %0d, cut %0d, noise %0d, undersized %0d",
			frames_made[FR_OK], frames_made[FR_BAD_MAGIC], frames_made[FR_BAD_VER],
			frames_made[FR_ZERO_LEN], frames_made[FR_NO_ROOM], frames_made[FR_CUT],
			frames_made[FR_NOISE], undersized_frames);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout with %0d of %0d pixels taken, %0d bytes outstanding",
			pixels_taken, pixels_queued, expected_bytes.size());
		$display("testbench: errors");
		$finish;
	end

endmodule
